@@ src/arpss_pkg.sv @@
// Shared types and constants for the arpeggiator step sequencer.
// No dependencies; imported by arpss_div and arpeggiator_step_sequencer.
`timescale 1ns / 1ps
`default_nettype none
package arpss_pkg;

  localparam int MAX_STEPS = 32;

  // widths of the shared divider
  localparam int DVD_W = 13;
  localparam int DVS_W = 7;
  localparam int DCNT_W = 4;

  // command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_NOTE = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_PATTERN = 3'd0;
  localparam logic [2:0] REG_OCTAVE  = 3'd1;
  localparam logic [2:0] REG_STEPS   = 3'd2;
  localparam logic [2:0] REG_GATE    = 3'd3;
  localparam logic [2:0] REG_SWING   = 3'd4;
  localparam logic [2:0] REG_PERIOD  = 3'd5;

  // pattern codes
  localparam logic [3:0] PAT_UP      = 4'd0;
  localparam logic [3:0] PAT_DOWN    = 4'd1;
  localparam logic [3:0] PAT_UPDOWN  = 4'd2;
  localparam logic [3:0] PAT_DOWNUP  = 4'd3;
  localparam logic [3:0] PAT_RANDOM  = 4'd4;
  localparam logic [3:0] PAT_DRUNK   = 4'd5;
  localparam logic [3:0] PAT_OCTAVE  = 4'd6;
  localparam logic [3:0] PAT_SPIRAL  = 4'd7;
  localparam logic [3:0] PAT_BOUNCE  = 4'd8;
  localparam logic [3:0] PAT_STUTTER = 4'd9;
  localparam logic [3:0] PAT_SKIP    = 4'd10;
  localparam logic [3:0] PAT_DOUBLE  = 4'd11;
  localparam logic [3:0] PAT_THIRDS  = 4'd12;
  localparam logic [3:0] PAT_FIFTHS  = 4'd13;
  localparam logic [3:0] PAT_BROKEN  = 4'd14;
  localparam logic [3:0] PAT_EUCLID  = 4'd15;

  // random-walk generator
  localparam logic [31:0] LCG_MUL  = 32'd1103515245;
  localparam logic [31:0] LCG_INC  = 32'd12345;
  localparam logic [31:0] LCG_SEED = 32'd12345;
  localparam logic [14:0] WALK_MID = 15'd16384;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  // chord intervals for the broken pattern
  function automatic logic [3:0] chord_tone(input logic [1:0] idx);
    logic [3:0] t;
    case (idx)
      2'd0: t = 4'd0;
      2'd1: t = 4'd4;
      2'd2: t = 4'd7;
      default: t = 4'd12;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

@@ src/arpeggiator_step_sequencer.sv @@
// Arpeggiator step sequencer top level: config registers, sequencer, output register.
// Depends on arpss_pkg and arpss_div.
//
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the six
//    registers; cfg_ready is always high, write only while the block is idle
//  - in channel takes one beat per command: tick (cmd 0), note on (cmd 1),
//    all notes off (cmd 2); cmd 3 is ignored
//  - note on, all notes off and cmd 3 finish in the accept cycle, no result
//  - every tick gives one out beat; when not running all fields are zero
//  - a tick passes through the step-length multiply, the advance, two
//    divider passes (step modulo the count, then the pattern quotient or
//    remainder) and the output state; while stopped it goes from the
//    step-length state straight to the output state; in_ready rises
//    together with out_valid
//  - in_ready is high only while the sequencer is idle; a result waiting
//    in the output register does not block the next accept, but the next
//    tick holds in its final cycle until that result is taken
//  - reset clears the sequencer to stopped, registers to their defaults
//    and the walk generator to its seed
`timescale 1ns / 1ps
`default_nettype none
module arpeggiator_step_sequencer
  import arpss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [19:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [6:0]        in_note,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_running,
  output logic [4:0]             out_step_index,
  output logic signed [5:0]      out_semitone,
  output logic                   out_silent,
  output logic                   out_gate_on,
  output logic                   out_accent_step,
  output logic [6:0]             out_held_note
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LEN  = 3'd1;
  localparam logic [2:0] ST_ADV  = 3'd2;
  localparam logic [2:0] ST_MODS = 3'd3;
  localparam logic [2:0] ST_MODW = 3'd4;
  localparam logic [2:0] ST_SET2 = 3'd5;
  localparam logic [2:0] ST_DIVW = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  // configuration registers
  logic [3:0]  pattern_r;
  logic [3:0]  octave_r;
  logic [5:0]  steps_r;
  logic [9:0]  gate_r;
  logic [9:0]  swing_r;
  logic [19:0] period_r;

  // sequencer state
  logic [2:0]         state_r, state_nxt;
  logic [4:0]         step_r;
  logic [20:0]        cnt_r;
  logic signed [4:0]  drunk_r;
  logic [31:0]        lcg_r;
  logic               active_r;
  logic               loop_r;
  logic [6:0]         note_r;
  logic               run_r;
  logic [20:0]        len_r;
  logic               gate_hit_r;
  logic [4:0]         s_r;

  // output register
  logic              out_valid_r;
  logic              o_run_r;
  logic [4:0]        o_step_r;
  logic signed [5:0] o_off_r;
  logic              o_silent_r;
  logic              o_gate_r;
  logic              o_accent_r;
  logic [6:0]        o_note_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  arpss_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // clamped loop length and octave span
  logic [5:0] n_eff;
  logic [4:0] half;
  logic [3:0] oct_eff;
  logic [6:0] oct12;
  always_comb begin
    if (steps_r < 6'd2) n_eff = 6'd2;
    else if (steps_r > 6'(MAX_STEPS)) n_eff = 6'(MAX_STEPS);
    else n_eff = steps_r;
    half = n_eff[5:1];
    if (octave_r < 4'd1) oct_eff = 4'd1;
    else if (octave_r > 4'd8) oct_eff = 4'd8;
    else oct_eff = octave_r;
    oct12 = 7'(oct_eff) * 7'd12;
  end

  // swing-stretched step length
  logic [31:0] swing_prod;
  logic [20:0] len_calc;
  assign swing_prod = 32'(period_r) * 32'(12'd1536 + 12'(swing_r));
  assign len_calc   = step_r[0] ? swing_prod[31:11] : {1'b0, period_r};

  // walk generator step
  logic [31:0] lcg_next;
  assign lcg_next = lcg_r * LCG_MUL + LCG_INC;

  // counter advance and gate compare
  logic [20:0] cnt_inc;
  logic        wrap;
  logic [5:0]  step_inc;
  logic [20:0] cnt_new;
  logic [31:0] gate_prod;
  assign cnt_inc   = cnt_r + 21'd1;
  assign wrap      = {1'b0, cnt_inc} >= {1'b0, len_r};
  assign step_inc  = {1'b0, step_r} + 6'd1;
  assign cnt_new   = wrap ? 21'd0 : cnt_inc;
  assign gate_prod = 32'(gate_r) * 32'(len_r);

  // second division operands per pattern
  logic [DVD_W-1:0] num2;
  logic [DVS_W-1:0] den2;
  logic [DVD_W-1:0] s13;
  logic [DVD_W-1:0] n13;
  logic [DVD_W-1:0] h13;
  always_comb begin
    s13  = DVD_W'(s_r);
    n13  = DVD_W'(n_eff);
    h13  = DVD_W'(half);
    num2 = '0;
    den2 = DVS_W'(1);
    case (pattern_r)
      PAT_UP: begin
        num2 = s13 * DVD_W'(12);
        den2 = DVS_W'(n_eff);
      end
      PAT_DOWN: begin
        num2 = (n13 - s13 - DVD_W'(1)) * DVD_W'(12);
        den2 = DVS_W'(n_eff);
      end
      PAT_UPDOWN: begin
        num2 = (s_r < half) ? s13 * DVD_W'(12) : (n13 - s13) * DVD_W'(12);
        den2 = DVS_W'(half);
      end
      PAT_DOWNUP: begin
        num2 = (s_r < half) ? (h13 - s13) * DVD_W'(12) : (s13 - h13) * DVD_W'(12);
        den2 = DVS_W'(half);
      end
      PAT_RANDOM: begin
        num2 = s13 * DVD_W'(137) + DVD_W'(157);
        den2 = oct12;
      end
      PAT_OCTAVE: begin
        num2 = s13;
        den2 = DVS_W'(oct_eff);
      end
      PAT_SPIRAL: begin
        num2 = DVD_W'(s_r[4:2]) * DVD_W'(3) + DVD_W'(s_r[1:0]) * DVD_W'(2);
        den2 = oct12;
      end
      PAT_STUTTER, PAT_SKIP, PAT_DOUBLE: begin
        num2 = DVD_W'(s_r[4:1]) * DVD_W'(12);
        den2 = DVS_W'(n_eff);
      end
      PAT_THIRDS: begin
        num2 = s13;
        den2 = DVS_W'(3);
      end
      PAT_BROKEN: begin
        num2 = DVD_W'(s_r[4:2]);
        den2 = DVS_W'(oct_eff);
      end
      PAT_EUCLID: begin
        num2 = DVD_W'(s_r[4:3]) * DVD_W'(12);
        den2 = DVS_W'(n_eff);
      end
      default: begin
        num2 = '0;
        den2 = DVS_W'(1);
      end
    endcase
  end

  // final offset from the second division
  logic signed [7:0] off;
  logic signed [7:0] q8;
  logic signed [7:0] r8;
  logic [2:0]        eu_pos;
  logic signed [5:0] off_clip;
  always_comb begin
    q8     = {1'b0, div_rsp.quot[6:0]};
    r8     = {1'b0, div_rsp.rem};
    eu_pos = 3'(s_r[2:0] * 3'd5);
    case (pattern_r)
      PAT_UP, PAT_DOWN, PAT_UPDOWN, PAT_DOWNUP, PAT_STUTTER, PAT_DOUBLE: off = q8;
      PAT_RANDOM, PAT_SPIRAL: off = r8;
      PAT_DRUNK:  off = 8'(drunk_r);
      PAT_OCTAVE: off = 8'(r8 * 8'sd12);
      PAT_BOUNCE: begin
        off = 8'(s_r[4:3]) * 8'sd12;
        if (!(s_r[2:0] == 3'd0 || s_r[2:0] == 3'd2 || s_r[2:0] == 3'd6)) begin
          off = off - 8'sd3;
        end
      end
      PAT_SKIP:   off = s_r[0] ? -8'sd1 : q8;
      PAT_THIRDS: off = 8'(r8 * 8'sd4);
      PAT_FIFTHS: off = s_r[0] ? 8'sd7 : 8'sd0;
      PAT_BROKEN: off = 8'(chord_tone(s_r[1:0])) + 8'(r8 * 8'sd12);
      PAT_EUCLID: off = (eu_pos < 3'd5) ? q8 : -8'sd1;
      default:    off = 8'sd0;
    endcase
    if (off > 8'sd24) off_clip = 6'sd24;
    else if (off < -8'sd24) off_clip = -6'sd24;
    else off_clip = off[5:0];
  end

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = DVS_W'(1);
    if (state_r == ST_MODS) begin
      div_req.start    = 1'b1;
      div_req.dividend = DVD_W'(step_r);
      div_req.divisor  = DVS_W'(n_eff);
    end else if (state_r == ST_SET2) begin
      div_req.start    = 1'b1;
      div_req.dividend = num2;
      div_req.divisor  = den2;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && in_cmd == CMD_TICK) state_nxt = ST_LEN;
      ST_LEN:  state_nxt = (active_r && loop_r) ? ST_ADV : ST_FIN;
      ST_ADV:  state_nxt = ST_MODS;
      ST_MODS: state_nxt = ST_MODW;
      ST_MODW: if (div_rsp.done) state_nxt = ST_SET2;
      ST_SET2: state_nxt = ST_DIVW;
      ST_DIVW: if (div_rsp.done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= 4'd0;
      octave_r  <= 4'd2;
      steps_r   <= 6'd8;
      gate_r    <= 10'd768;
      swing_r   <= 10'd512;
      period_r  <= 20'd6000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PATTERN: pattern_r <= cfg_data[3:0];
        REG_OCTAVE:  octave_r  <= cfg_data[3:0];
        REG_STEPS:   steps_r   <= cfg_data[5:0];
        REG_GATE:    gate_r    <= cfg_data[9:0];
        REG_SWING:   swing_r   <= cfg_data[9:0];
        REG_PERIOD:  period_r  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= '0;
      cnt_r    <= '0;
      drunk_r  <= '0;
      lcg_r    <= LCG_SEED;
      active_r <= 1'b0;
      loop_r   <= 1'b0;
      note_r   <= '0;
      run_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_cmd == CMD_NOTE) begin
              note_r <= in_note;
              if (active_r && loop_r) begin
                loop_r <= 1'b0;
              end else begin
                active_r <= 1'b1;
                loop_r   <= 1'b1;
                step_r   <= '0;
                cnt_r    <= '0;
                drunk_r  <= '0;
              end
            end else if (in_cmd == CMD_STOP) begin
              active_r <= 1'b0;
              loop_r   <= 1'b0;
            end
          end
        end
        ST_LEN: begin
          run_r <= active_r && loop_r;
          if (active_r && loop_r && pattern_r == PAT_DRUNK) begin
            lcg_r <= lcg_next;
            if (lcg_next[14:0] > WALK_MID) begin
              if (drunk_r < 5'sd12) drunk_r <= drunk_r + 5'sd1;
            end else begin
              if (drunk_r > -5'sd12) drunk_r <= drunk_r - 5'sd1;
            end
          end
        end
        ST_ADV: begin
          cnt_r <= cnt_new;
          if (wrap) step_r <= (step_inc >= n_eff) ? 5'd0 : step_inc[4:0];
        end
        default: ;
      endcase
    end
  end

  // step length, gate result and step residue
  always_ff @(posedge clk) begin
    if (state_r == ST_LEN) len_r <= len_calc;
    if (state_r == ST_ADV) gate_hit_r <= {1'b0, cnt_new, 10'd0} < gate_prod;
    if (state_r == ST_MODW && div_rsp.done) s_r <= div_rsp.rem[4:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (state_r == ST_FIN && out_free) begin
      o_run_r    <= run_r;
      o_step_r   <= run_r ? step_r : 5'd0;
      o_off_r    <= run_r ? off_clip : 6'sd0;
      o_silent_r <= run_r && off_clip == -6'sd1;
      o_gate_r   <= run_r && off_clip != -6'sd1 && gate_hit_r;
      o_accent_r <= run_r && step_r[1:0] == 2'd0;
      o_note_r   <= run_r ? note_r : 7'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_running     = o_run_r;
  assign out_step_index  = o_step_r;
  assign out_semitone    = o_off_r;
  assign out_silent      = o_silent_r;
  assign out_gate_on     = o_gate_r;
  assign out_accent_step = o_accent_r;
  assign out_held_note   = o_note_r;

  // checks
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_MODW || state_r == ST_DIVW))
    else $error("divider finished outside a wait state");

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (drunk_r <= 5'sd12) && (drunk_r >= -5'sd12))
    else $error("random walk out of range");

  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == CMD_TICK) |=> (state_r == ST_LEN))
    else $error("accepted tick did not start the sequencer");

  a_silent_no_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_silent) |-> !out_gate_on)
    else $error("gate on a muted step");

  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_running) |-> (out_semitone == 6'sd0 && out_held_note == 7'd0))
    else $error("fields not cleared when stopped");

endmodule
`default_nettype wire

@@ src/arpss_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on arpss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module arpss_div
  import arpss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W:0]    rem_r, rem_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DVS_W:0]    trial;

  // one shift-and-subtract step per cycle
  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DVS_W-1:0], dvd_r[DVD_W-1]};
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = DCNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;
  assign rsp.rem  = rem_r[DVS_W-1:0];

endmodule
`default_nettype wire
